// ----- rtl/core/sci_pkg.sv -----
// Shared types, codes and helpers for the serial motor command interpreter.
package sci_pkg;

	localparam logic [2:0] R_NONE     = 3'd0;
	localparam logic [2:0] R_STOPPED  = 3'd1;
	localparam logic [2:0] R_HELP     = 3'd2;
	localparam logic [2:0] R_SET      = 3'd3;
	localparam logic [2:0] R_WAIT     = 3'd4;
	localparam logic [2:0] R_BAD_NUM  = 3'd5;
	localparam logic [2:0] R_UNKNOWN  = 3'd6;
	localparam logic [2:0] R_TOO_LONG = 3'd7;

	localparam logic [2:0] K_EMPTY   = 3'd0;
	localparam logic [2:0] K_STOP    = 3'd1;
	localparam logic [2:0] K_HELP    = 3'd2;
	localparam logic [2:0] K_SPEED   = 3'd3;
	localparam logic [2:0] K_BAD_NUM = 3'd4;
	localparam logic [2:0] K_UNKNOWN = 3'd5;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_M     = 8'h6D;
	localparam logic [7:0] CH_NUL   = 8'h00;

	localparam logic [15:0] PAUSE_RESET = 16'd500;
	localparam logic [6:0]  SPEED_MAX   = 7'd100;

	// (x * 5243) >> 19 equals x / 100 for every x up to 25550 used here
	localparam logic [12:0] DUTY_RECIP = 13'd5243;
	localparam logic [15:0] DUTY_ROUND = 16'd50;

	typedef struct packed {
		logic [2:0]        kind;
		logic signed [7:0] speed;
	} scan_res_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic [7:0] help_char(input logic [1:0] k);
		logic [7:0] c;
		case (k)
			2'd0: c = 8'h68;
			2'd1: c = 8'h65;
			2'd2: c = 8'h6C;
			default: c = 8'h70;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] duty_of(input logic signed [7:0] sp);
		logic [7:0]  mag;
		logic [15:0] x;
		logic [28:0] p;
		mag = sp[7] ? 8'(-sp) : 8'(sp);
		x = {mag, 8'h00} - {8'h00, mag} + DUTY_ROUND;
		p = 29'(x) * 29'(DUTY_RECIP);
		return p[26:19];
	endfunction

endpackage

// ----- rtl/core/sci_line_mem.sv -----
// Line store: one write port, one read port with registered data.
module sci_line_mem #(
	parameter int DEPTH = 48,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/sci_scan.sv -----
// Line scanner: trim pass over the line store, then a parse pass over the trimmed text.
module sci_scan import sci_pkg::*; #(
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [AW-1:0] len,
	output logic [AW-1:0] raddr,
	input  logic [7:0]    rdata,
	output logic          done,
	output scan_res_t     res
);

	localparam logic [1:0] SC_IDLE  = 2'd0;
	localparam logic [1:0] SC_TRIM  = 2'd1;
	localparam logic [1:0] SC_PARSE = 2'd2;

	localparam logic [1:0] PH_LEAD = 2'd0;
	localparam logic [1:0] PH_SIGN = 2'd1;
	localparam logic [1:0] PH_DIG  = 2'd2;

	logic [1:0]    st_q;
	logic [AW-1:0] ptr_q, end_q, idx_s1, beg_q, last_q;
	logic          vld_s1, found_q;
	logic          s_q, help_q, m_q, bad_q, neg_q, over_q;
	logic [1:0]    ph_q;
	logic [6:0]    val_q;
	logic          done_q;
	scan_res_t     res_q;

	logic [AW-1:0]     k, span;
	logic              issue, trim_done, parse_done, dig, ws;
	logic [10:0]       nv;
	logic signed [7:0] sp;
	scan_res_t         pick;

	always_comb begin
		k          = idx_s1 - beg_q;
		span       = last_q - beg_q;
		issue      = ptr_q != end_q;
		trim_done  = (vld_s1 && rdata == CH_NUL) || (!vld_s1 && !issue);
		parse_done = !vld_s1 && !issue;
		dig        = rdata >= CH_ZERO && rdata <= CH_NINE;
		ws         = is_ws(rdata);
		nv         = 11'(val_q) * 11'd10 + 11'(rdata[3:0]);
		sp         = neg_q ? 8'(-{1'b0, val_q}) : {1'b0, val_q};
		pick.speed = sp;
		if (span == '0) begin
			pick.kind = s_q ? K_STOP : K_UNKNOWN;
		end else if (span == AW'(3) && help_q) begin
			pick.kind = K_HELP;
		end else if (m_q) begin
			pick.kind = (ph_q == PH_DIG && !bad_q && !over_q) ? K_SPEED : K_BAD_NUM;
		end else begin
			pick.kind = K_UNKNOWN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= SC_IDLE;
			ptr_q   <= '0;
			end_q   <= '0;
			idx_s1  <= '0;
			vld_s1  <= 1'b0;
			found_q <= 1'b0;
			beg_q   <= '0;
			last_q  <= '0;
			s_q     <= 1'b0;
			help_q  <= 1'b0;
			m_q     <= 1'b0;
			bad_q   <= 1'b0;
			neg_q   <= 1'b0;
			over_q  <= 1'b0;
			ph_q    <= PH_LEAD;
			val_q   <= '0;
			done_q  <= 1'b0;
			res_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				SC_IDLE: begin
					if (start) begin
						ptr_q   <= '0;
						end_q   <= len;
						vld_s1  <= 1'b0;
						found_q <= 1'b0;
						st_q    <= SC_TRIM;
					end
				end
				SC_TRIM: begin
					if (trim_done) begin
						vld_s1 <= 1'b0;
						if (!found_q) begin
							res_q  <= '{kind: K_EMPTY, speed: '0};
							done_q <= 1'b1;
							st_q   <= SC_IDLE;
						end else begin
							ptr_q  <= beg_q;
							end_q  <= last_q + AW'(1);
							s_q    <= 1'b0;
							help_q <= 1'b1;
							m_q    <= 1'b1;
							bad_q  <= 1'b0;
							neg_q  <= 1'b0;
							over_q <= 1'b0;
							ph_q   <= PH_LEAD;
							val_q  <= '0;
							st_q   <= SC_PARSE;
						end
					end else begin
						if (vld_s1 && !ws) begin
							if (!found_q) begin
								found_q <= 1'b1;
								beg_q   <= idx_s1;
							end
							last_q <= idx_s1;
						end
						vld_s1 <= issue;
						if (issue) begin
							idx_s1 <= ptr_q;
							ptr_q  <= ptr_q + AW'(1);
						end
					end
				end
				SC_PARSE: begin
					if (parse_done) begin
						res_q  <= pick;
						done_q <= 1'b1;
						st_q   <= SC_IDLE;
					end else begin
						if (vld_s1) begin
							if (k < AW'(4) && rdata != help_char(k[1:0])) begin
								help_q <= 1'b0;
							end
							if (k == '0) begin
								s_q <= rdata == CH_S;
								if (rdata != CH_M) begin
									m_q <= 1'b0;
								end
							end else if (k == AW'(1)) begin
								if (!ws) begin
									m_q <= 1'b0;
								end
							end else begin
								case (ph_q)
									PH_LEAD: begin
										if (rdata == CH_PLUS || rdata == CH_MINUS) begin
											neg_q <= rdata == CH_MINUS;
											ph_q  <= PH_SIGN;
										end else if (dig) begin
											ph_q <= PH_DIG;
										end else if (!ws) begin
											bad_q <= 1'b1;
										end
									end
									PH_SIGN: begin
										if (dig) begin
											ph_q <= PH_DIG;
										end else begin
											bad_q <= 1'b1;
										end
									end
									default: begin
										if (!dig) begin
											bad_q <= 1'b1;
										end
									end
								endcase
								if (dig && ph_q != PH_LEAD || dig) begin
									val_q <= nv[6:0];
									if (nv > 11'(SPEED_MAX)) begin
										over_q <= 1'b1;
									end
								end
							end
						end
						vld_s1 <= issue;
						if (issue) begin
							idx_s1 <= ptr_q;
							ptr_q  <= ptr_q + AW'(1);
						end
					end
				end
				default: begin
					st_q <= SC_IDLE;
				end
			endcase
		end
	end

	assign raddr = ptr_q;
	assign done  = done_q;
	assign res   = res_q;

endmodule

// ----- rtl/core/sci_motor.sv -----
// Motor state: speed, last direction, stop timer and the reply of a finished line.
module sci_motor import sci_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tick,
	input  logic              exec,
	input  scan_res_t         cmd,
	input  logic [15:0]       pause,
	output logic signed [7:0] speed,
	output logic [2:0]        reply
);

	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_FWD  = 2'd1;
	localparam logic [1:0] DIR_REV  = 2'd2;

	logic signed [7:0] speed_q;
	logic [1:0]        dir_q;
	logic [15:0]       ms_q;
	logic [2:0]        reply_q;

	logic [1:0]  new_dir;
	logic        running, rev, hold;
	logic [15:0] ms_after;

	always_comb begin
		new_dir  = cmd.speed[7] ? DIR_REV : DIR_FWD;
		running  = speed_q != 0;
		rev      = dir_q != DIR_NONE && new_dir != dir_q;
		ms_after = running ? '0 : ms_q;
		hold     = rev && ms_after < pause;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= '0;
			dir_q   <= DIR_NONE;
			ms_q    <= '0;
			reply_q <= R_NONE;
		end else if (tick) begin
			if (ms_q != 16'hFFFF) begin
				ms_q <= ms_q + 16'd1;
			end
		end else if (exec) begin
			case (cmd.kind)
				K_STOP: begin
					speed_q <= '0;
					ms_q    <= ms_after;
					reply_q <= R_STOPPED;
				end
				K_SPEED: begin
					if (cmd.speed == 0 || hold) begin
						speed_q <= '0;
						ms_q    <= ms_after;
						reply_q <= (cmd.speed == 0) ? R_SET : R_WAIT;
					end else begin
						if (rev) begin
							ms_q <= ms_after;
						end
						speed_q <= cmd.speed;
						dir_q   <= new_dir;
						reply_q <= R_SET;
					end
				end
				K_HELP:    reply_q <= R_HELP;
				K_BAD_NUM: reply_q <= R_BAD_NUM;
				K_UNKNOWN: reply_q <= R_UNKNOWN;
				default:   reply_q <= R_NONE;
			endcase
		end
	end

	assign speed = speed_q;
	assign reply = reply_q;

endmodule

// ----- rtl/core/serial_motor_command_interpreter.sv -----
// Top level: item handshakes, register port, line buffer control and result register.
//
//  channel | signals                                         | item moves when
//  --------+-------------------------------------------------+-------------------------
//  in      | in_valid in_ready cmd rx_byte                   | in_valid && in_ready
//  out     | out_valid out_ready reply speed_percent         | out_valid && out_ready
//          | drive_forward drive_reverse duty                |
//  apb     | psel penable pwrite paddr pwdata prdata pready  | psel && penable
//
// For ticks and ordinary bytes the result is registered at acceptance.
// A line end starts a scan of the line store, one read per cycle, once to trim the line
// and once to parse the trimmed text.
// No clearing pass after reset; items are accepted from the first edge after arst_n rises.
// A result waiting on out_ready holds the next item off only if out_ready stays low.
module serial_motor_command_interpreter import sci_pkg::*; #(
	parameter int LINE_BYTES = 48
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              cmd,
	input  logic [7:0]        rx_byte,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        reply,
	output logic signed [7:0] speed_percent,
	output logic              drive_forward,
	output logic              drive_reverse,
	output logic [7:0]        duty,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int            AW      = $clog2(LINE_BYTES);
	localparam logic [AW-1:0] LEN_MAX = AW'(LINE_BYTES - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_POST = 2'd2;

	logic [1:0]        st_q;
	logic [AW-1:0]     len_q;
	logic              ovf_q;
	logic [15:0]       pause_q;
	logic              ov_q;
	logic [2:0]        reply_q;
	logic signed [7:0] speed_q;
	logic              fwd_q, rev_q;
	logic [7:0]        duty_q;

	logic              acc, is_eol, store, start, load;
	logic [2:0]        load_reply;
	logic [AW-1:0]     raddr;
	logic [7:0]        rdata;
	logic              scan_done;
	scan_res_t         scan_res;
	logic signed [7:0] mot_speed;
	logic [2:0]        mot_reply;

	always_comb begin
		in_ready   = st_q == ST_IDLE && (!ov_q || out_ready);
		acc        = in_valid && in_ready;
		is_eol     = !cmd && (rx_byte == CH_LF || rx_byte == CH_CR);
		store      = acc && !cmd && !is_eol && !ovf_q && len_q < LEN_MAX;
		start      = acc && is_eol && !ovf_q;
		load       = (acc && !start) || st_q == ST_POST;
		load_reply = (st_q == ST_POST) ? mot_reply : ((acc && is_eol) ? R_TOO_LONG : R_NONE);
	end

	sci_line_mem #(
		.DEPTH (LINE_BYTES),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (store),
		.waddr (len_q),
		.wdata (rx_byte),
		.raddr (raddr),
		.rdata (rdata)
	);

	sci_scan #(
		.AW (AW)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.len    (len_q),
		.raddr  (raddr),
		.rdata  (rdata),
		.done   (scan_done),
		.res    (scan_res)
	);

	sci_motor u_motor (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (acc && cmd),
		.exec   (scan_done),
		.cmd    (scan_res),
		.pause  (pause_q),
		.speed  (mot_speed),
		.reply  (mot_reply)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			len_q   <= '0;
			ovf_q   <= 1'b0;
			pause_q <= PAUSE_RESET;
			ov_q    <= 1'b0;
		end else begin
			if (psel && penable && pwrite && !paddr[2]) begin
				pause_q <= pwdata[15:0];
			end
			case (st_q)
				ST_IDLE: begin
					if (acc && !cmd) begin
						if (is_eol) begin
							len_q <= '0;
							ovf_q <= 1'b0;
							if (start) begin
								st_q <= ST_SCAN;
							end
						end else if (store) begin
							len_q <= len_q + AW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						st_q <= ST_POST;
					end
				end
				ST_POST: begin
					st_q <= ST_IDLE;
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
			if (load) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			reply_q <= load_reply;
			speed_q <= mot_speed;
			fwd_q   <= !mot_speed[7] && mot_speed != 0;
			rev_q   <= mot_speed[7];
			duty_q  <= duty_of(mot_speed);
		end
	end

	assign out_valid     = ov_q;
	assign reply         = reply_q;
	assign speed_percent = speed_q;
	assign drive_forward = fwd_q;
	assign drive_reverse = rev_q;
	assign duty          = duty_q;
	assign prdata        = paddr[2] ? 32'h0 : {16'h0, pause_q};
	assign pready        = 1'b1;

endmodule

// ----- rtl/core/sci_checker.sv -----
// Port-level checks on the interpreter's results, bound to the top level.
module sci_checker import sci_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              cmd,
	input logic              out_valid,
	input logic              out_ready,
	input logic [2:0]        reply,
	input logic signed [7:0] speed_percent,
	input logic              drive_forward,
	input logic              drive_reverse,
	input logic [7:0]        duty
);

	a_dir_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (drive_forward == (speed_percent > 8'sd0))
			&& (drive_reverse == (speed_percent < 8'sd0)))
		else $error("bridge inputs disagree with speed");

	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (speed_percent <= 8'sd100) && (speed_percent >= -8'sd100))
		else $error("speed out of range");

	a_stop_duty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && speed_percent == 8'sd0 |-> duty == 8'd0)
		else $error("duty nonzero while stopped");

	a_tick_reply: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && cmd |=> out_valid && reply == R_NONE)
		else $error("tick item gave no plain result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(reply) && $stable(speed_percent))
		else $error("pending result changed");

endmodule

bind serial_motor_command_interpreter sci_checker u_sci_checker (.*);
